>>> src/sle_pkg.sv
`default_nettype none

package sle_pkg;

    // Deepest line the buffer can hold; the effective line size is clamped to this.
    localparam int MAX_LINE = 256;
    localparam int LINE_TOP = (MAX_LINE < 256) ? MAX_LINE : 256;

    localparam int CODE_W = 8;
    localparam int POS_W  = 8;
    localparam int CHAR_W = 7;
    localparam int SIZE_W = 9;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_TOP   = SIZE_W'(LINE_TOP);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    // Set-1 scan codes
    localparam logic [CODE_W-1:0] CODE_LSHIFT    = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT    = 8'h36;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_UP = 8'hAA;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_UP = 8'hB6;
    localparam logic [CODE_W-1:0] CODE_ENTER     = 8'h1C;
    localparam logic [CODE_W-1:0] CODE_BKSP      = 8'h0E;
    localparam int                BREAK_BIT      = 7;
    localparam int                ROM_SIZE       = 58;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS  = 7'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 7'h0A;

    localparam logic [CHAR_W-1:0] ROM_LOWER [0:ROM_SIZE-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] ROM_UPPER [0:ROM_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // One buffer write with its echo
    typedef struct packed {
        logic [POS_W-1:0]  write_position;
        logic [CHAR_W-1:0] write_char;
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              line_done;
        logic              last_result;
    } result_t;

    // Results produced by one scan code
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } edit_out_t;

    function automatic logic [CHAR_W-1:0] rom_char(input logic [CODE_W-1:0] code,
                                                   input logic upper);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_NUL;
        if (code < CODE_W'(ROM_SIZE)) begin
            ch = upper ? ROM_UPPER[code[5:0]] : ROM_LOWER[code[5:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> src/sle_in_stage.sv
`default_nettype none

module sle_in_stage (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sle_pkg::CODE_W-1:0] s_tdata,
    input  wire logic                      room,
    output logic                           advance,
    output logic [sle_pkg::CODE_W-1:0]     code
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [sle_pkg::CODE_W-1:0] code_reg;

    assign advance  = valid_reg & room;
    assign s_tready = ~valid_reg | advance;
    assign code     = code_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            code_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> src/sle_edit.sv
`default_nettype none

module sle_edit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [sle_pkg::SIZE_W-1:0] cfg_wdata,
    input  wire logic                       advance,
    input  wire logic [sle_pkg::CODE_W-1:0] code,
    output sle_pkg::edit_out_t              edit_out
);

    logic [sle_pkg::SIZE_W-1:0] size_reg;
    logic                       shift_reg;
    logic                       shift_next;
    logic [sle_pkg::POS_W-1:0]  len_reg;
    logic [sle_pkg::POS_W-1:0]  len_next;

    logic [sle_pkg::SIZE_W-1:0] size_eff;
    logic [sle_pkg::SIZE_W-1:0] limit;
    logic [sle_pkg::SIZE_W-1:0] pos_p1;
    logic [sle_pkg::CHAR_W-1:0] ch;
    logic                       full;

    // effective size clamped to 2..LINE_TOP; line ends at size - 1
    always_comb begin
        size_eff = size_reg;
        if (size_eff < sle_pkg::SIZE_MIN) begin
            size_eff = sle_pkg::SIZE_MIN;
        end
        if (size_eff > sle_pkg::SIZE_TOP) begin
            size_eff = sle_pkg::SIZE_TOP;
        end
    end

    assign limit  = size_eff - sle_pkg::SIZE_W'(1);
    assign pos_p1 = {1'b0, len_reg} + sle_pkg::SIZE_W'(1);
    assign full   = (pos_p1 >= limit);
    assign ch     = sle_pkg::rom_char(code, shift_reg);

    always_comb begin
        shift_next      = shift_reg;
        len_next        = len_reg;
        edit_out        = '0;
        if (code == sle_pkg::CODE_LSHIFT || code == sle_pkg::CODE_RSHIFT) begin
            shift_next = 1'b1;
        end else if (code == sle_pkg::CODE_LSHIFT_UP || code == sle_pkg::CODE_RSHIFT_UP) begin
            shift_next = 1'b0;
        end else if (code[sle_pkg::BREAK_BIT]) begin
            shift_next = shift_reg;
        end else if (code == sle_pkg::CODE_ENTER) begin
            edit_out.count                    = 2'd1;
            edit_out.first.write_position     = len_reg;
            edit_out.first.write_char         = sle_pkg::CHAR_NUL;
            edit_out.first.echo_valid         = 1'b1;
            edit_out.first.echo_char          = sle_pkg::CHAR_LF;
            edit_out.first.line_done          = 1'b1;
            edit_out.first.last_result        = 1'b1;
            shift_next                        = 1'b0;
            len_next                          = '0;
        end else if (code == sle_pkg::CODE_BKSP) begin
            if (len_reg != '0) begin
                len_next                      = len_reg - sle_pkg::POS_W'(1);
                edit_out.count                = 2'd1;
                edit_out.first.write_position = len_reg - sle_pkg::POS_W'(1);
                edit_out.first.write_char     = sle_pkg::CHAR_NUL;
                edit_out.first.echo_valid     = 1'b1;
                edit_out.first.echo_char      = sle_pkg::CHAR_BS;
                edit_out.first.line_done      = 1'b0;
                edit_out.first.last_result    = 1'b1;
            end
        end else if (ch != sle_pkg::CHAR_NUL) begin
            edit_out.first.write_position = len_reg;
            edit_out.first.write_char     = ch;
            edit_out.first.echo_valid     = 1'b1;
            edit_out.first.echo_char      = ch;
            edit_out.first.line_done      = 1'b0;
            if (full) begin
                // line full: terminator follows the char
                edit_out.count                 = 2'd2;
                edit_out.first.last_result     = 1'b0;
                edit_out.second.write_position = pos_p1[sle_pkg::POS_W-1:0];
                edit_out.second.write_char     = sle_pkg::CHAR_NUL;
                edit_out.second.echo_valid     = 1'b0;
                edit_out.second.echo_char      = sle_pkg::CHAR_NUL;
                edit_out.second.line_done      = 1'b1;
                edit_out.second.last_result    = 1'b1;
                shift_next                     = 1'b0;
                len_next                       = '0;
            end else begin
                edit_out.count             = 2'd1;
                edit_out.first.last_result = 1'b1;
                len_next                   = pos_p1[sle_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= sle_pkg::SIZE_RESET;
            shift_reg <= 1'b0;
            len_reg   <= '0;
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (advance) begin
                shift_reg <= shift_next;
                len_reg   <= len_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/sle_out_queue.sv
`default_nettype none

module sle_out_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  sle_pkg::edit_out_t      edit_out,
    output logic                    room,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output sle_pkg::result_t        head
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    sle_pkg::result_t q0_reg;
    sle_pkg::result_t q0_next;
    sle_pkg::result_t q1_reg;
    logic             pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid & m_tready;
    assign head     = q0_reg;
    // a new item needs both slots free once this cycle's pop is taken
    assign room     = (cnt_reg == 2'd0) | ((cnt_reg == 2'd1) & m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        if (advance) begin
            cnt_next = edit_out.count;
            q0_next  = edit_out.first;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            q0_next  = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        if (advance) begin
            q1_reg <= edit_out.second;
        end
    end

endmodule

`default_nettype wire

>>> src/scancode_line_editor.sv
`default_nettype none

// Channel   | Dir | Handshake          | Contents
// ----------+-----+--------------------+----------------------------------------
// s_        | in  | s_tvalid/s_tready  | one set-1 scan code per item
// m_        | out | m_tvalid/m_tready  | buffer write + echo; tlast = last result
// cfg_      | in  | cfg_we             | max_line_size, 9 bits
//
// Path: a code is registered on accept; its results load the output queue once
//   the queue has room, and the first result is then offered from its head.
// Throughput: one item per cycle while m_tready stays high; an item that fills
//   the line yields two results and holds the input until the first is popped.
// Reset: synchronous, active low; shift flag and length clear, size = 256.
// Stalls: m_tready low holds the queue; s_tready drops once the queue lacks room.

module scancode_line_editor (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_code

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] write_position, [14:8] write_char,
                                        // [15] echo_valid, [22:16] echo_char, [23] zero
    output logic             m_tlast,   // last_result
    output logic             m_tuser    // line_done
);

    logic                       room;
    logic                       advance;
    logic [sle_pkg::CODE_W-1:0] code;
    sle_pkg::edit_out_t         edit_out;
    sle_pkg::result_t           head;

    // input register
    sle_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .room     (room),
        .advance  (advance),
        .code     (code)
    );

    // decode, ROM lookup, shift/length state
    sle_edit u_edit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .code      (code),
        .edit_out  (edit_out)
    );

    // two-entry result queue, head drives the master port
    sle_out_queue u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .edit_out (edit_out),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {1'b0, head.echo_char, head.echo_valid, head.write_char,
                      head.write_position};
    assign m_tlast = head.last_result;
    assign m_tuser = head.line_done;

`ifndef NO_ASSERTIONS
    // a non-final result is always the char before a line-full terminator
    a_full_term_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast && m_tuser))
        else $error("line-full terminator missing after char");

    // the terminator always closes the results of its item
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("line_done without last_result");

    // terminator writes NUL
    a_done_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[14:8] == sle_pkg::CHAR_NUL))
        else $error("terminator char not NUL");

    // the edit stage only fires into an empty queue or one popping its last entry in the same cycle
    a_room_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (!m_tvalid || (m_tready && m_tlast)))
        else $error("advance into occupied queue");
`endif

endmodule

`default_nettype wire

>>> test/line_edit_checker.sv
`timescale 1ns / 1ps

// Watches the config write, the scan code stream and the write/echo stream of the
// line editor, predicts every buffer write and compares it on arrival.
module line_edit_checker
    import sle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        m_tuser,
    output int               mismatches,
    output int               writes_pending
);

    logic [SIZE_W-1:0] line_size;
    logic              shift_held;
    logic [POS_W-1:0]  line_len;
    result_t           expected_writes[$];

    initial begin
        mismatches     = 0;
        writes_pending = 0;
    end

    function automatic result_t make_write(input logic [POS_W-1:0] pos,
                                           input logic [CHAR_W-1:0] wr_char,
                                           input logic echo_on,
                                           input logic [CHAR_W-1:0] echo,
                                           input logic done,
                                           input logic last);
        result_t w;
        w.write_position = pos;
        w.write_char     = wr_char;
        w.echo_valid     = echo_on;
        w.echo_char      = echo;
        w.line_done      = done;
        w.last_result    = last;
        return w;
    endfunction

    // Applies one scan code to the line state and queues the writes it causes.
    function automatic void edit_line(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        int                limit;
        int                pos;
        limit = int'(line_size);
        if (limit < int'(SIZE_MIN)) limit = int'(SIZE_MIN);
        if (limit > int'(SIZE_TOP)) limit = int'(SIZE_TOP);
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_held = 1'b1;
        end else if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) begin
            shift_held = 1'b0;
        end else if (!code[BREAK_BIT]) begin
            if (code == CODE_ENTER) begin
                expected_writes.push_back(make_write(line_len, CHAR_NUL, 1'b1, CHAR_LF,
                                                     1'b1, 1'b1));
                shift_held = 1'b0;
                line_len   = '0;
            end else if (code == CODE_BKSP) begin
                if (line_len != '0) begin
                    line_len = line_len - 1'b1;
                    expected_writes.push_back(make_write(line_len, CHAR_NUL, 1'b1, CHAR_BS,
                                                         1'b0, 1'b1));
                end
            end else if (code < ROM_SIZE) begin
                ch = shift_held ? ROM_UPPER[code] : ROM_LOWER[code];
                if (ch != CHAR_NUL) begin
                    pos      = int'(line_len);
                    line_len = line_len + 1'b1;
                    if (pos + 1 >= limit - 1) begin
                        // line full: char, then terminator right behind it
                        expected_writes.push_back(make_write(POS_W'(pos), ch, 1'b1, ch,
                                                             1'b0, 1'b0));
                        expected_writes.push_back(make_write(POS_W'(pos + 1), CHAR_NUL,
                                                             1'b0, CHAR_NUL, 1'b1, 1'b1));
                        shift_held = 1'b0;
                        line_len   = '0;
                    end else begin
                        expected_writes.push_back(make_write(POS_W'(pos), ch, 1'b1, ch,
                                                             1'b0, 1'b1));
                    end
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        result_t     want;
        logic [23:0] want_data;
        if (!aresetn) begin
            line_size  = SIZE_RESET;
            shift_held = 1'b0;
            line_len   = '0;
            expected_writes.delete();
        end else begin
            if (cfg_we) line_size = cfg_wdata;
            if (s_tvalid && s_tready) edit_line(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected write: tdata=%h tlast=%b tuser=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    want      = expected_writes.pop_front();
                    want_data = {1'b0, want.echo_char, want.echo_valid, want.write_char,
                                 want.write_position};
                    if (m_tdata !== want_data || m_tlast !== want.last_result ||
                        m_tuser !== want.line_done) begin
                        if (mismatches < 10)
                            $display("%0t: write mismatch: exp tdata=%h tlast=%b tuser=%b, got tdata=%h tlast=%b tuser=%b",
                                     $realtime, want_data, want.last_result, want.line_done,
                                     m_tdata, m_tlast, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        writes_pending = expected_writes.size();
    end

endmodule

>>> test/tb_scancode_line_editor.sv
`timescale 1ns / 1ps

// Top of the line editor bench: clock, reset, scan code stimulus, receiver
// back-pressure and the verdict. All prediction and comparison is in the checker.
module tb_scancode_line_editor;
    import sle_pkg::*;

    localparam int HOLD_AT    = 200;    // items sent before the long receiver hold
    localparam int LONG_HOLD  = 200;    // cycles of the long receiver hold
    localparam int SETTLE     = 6;      // covers the input-register hop of no-result items
    localparam int DRAIN_CAP  = 20000;  // cycles allowed for the queue to empty

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] scan_code
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] write_position, [14:8] write_char,
                              // [15] echo_valid, [22:16] echo_char, [23] zero
    logic        m_tlast;     // last_result
    logic        m_tuser;     // line_done

    int mismatches;
    int writes_pending;
    int codes_sent;
    bit no_gaps;              // set per phase: sender offers back to back

    scancode_line_editor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    line_edit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .writes_pending (writes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest legal run (every gap and stall at its max).
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random keystroke. Most are printable make codes; the rest are enter,
    // backspace, shift make/break and raw noise (breaks, unmapped codes).
    function automatic logic [7:0] pick_scan_code(input int enter_pct, input int bksp_pct,
                                                  input bit long_line);
        int         r;
        int         noise_pct;
        logic [7:0] code;
        noise_pct = long_line ? 3 : 12;
        r = $urandom_range(0, 99);
        if (r < enter_pct) return CODE_ENTER;
        r -= enter_pct;
        if (r < bksp_pct) return CODE_BKSP;
        r -= bksp_pct;
        if (r < 4) begin
            case ($urandom_range(0, 3))
                0: return CODE_LSHIFT;
                1: return CODE_RSHIFT;
                2: return CODE_LSHIFT_UP;
                default: return CODE_RSHIFT_UP;
            endcase
        end
        r -= 4;
        if (r < noise_pct) return 8'($urandom_range(0, 255));
        code = 8'($urandom_range(0, ROM_SIZE - 1));
        while (ROM_LOWER[code] == CHAR_NUL) code = 8'($urandom_range(0, ROM_SIZE - 1));
        return code;
    endfunction

    // One item: optional idle gap, then hold valid until the handshake.
    task automatic send_code(input logic [7:0] code);
        int gap;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        codes_sent++;
    endtask

    // Stop offering and wait until every predicted write has come back,
    // then wait out the SETTLE margin for codes that produce nothing.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
            guard++;
        end while (writes_pending != 0 && guard < DRAIN_CAP);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Size register is only touched with the editor idle.
    task automatic set_line_size(input logic [8:0] size);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input int count, input int enter_pct, input int bksp_pct,
                               input bit long_line);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) send_code(pick_scan_code(enter_pct, bksp_pct, long_line));
        no_gaps = 1'b0;
    endtask

    // Receiver: random ready/stall runs, plus one long hold once the stream is
    // well under way so the output queue fills and the input backs up.
    initial begin : receiver
        bit long_hold_done;
        int hi;
        int lo;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!long_hold_done && codes_sent >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            hi = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (hi) @(posedge aclk);
            lo = idle_cycles();
            if (lo > 0) begin
                m_tready <= 1'b0;
                repeat (lo) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int guard;
        codes_sent = 0;
        no_gaps    = 1'b0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset size (256).
        send_code(CODE_BKSP);        // backspace on an empty line: nothing
        send_code(8'h10);            // q
        send_code(CODE_LSHIFT);
        send_code(8'h10);            // Q
        send_code(CODE_LSHIFT_UP);
        send_code(8'h02);            // 1
        send_code(CODE_RSHIFT);
        send_code(8'h02);            // !
        send_code(CODE_RSHIFT_UP);
        send_code(CODE_BKSP);
        send_code(8'h00);            // zero table entry: nothing
        send_code(8'h3A);            // first code past the tables: nothing
        send_code(8'h7F);            // highest make code: nothing
        send_code(8'hFF);            // break codes: ignored
        send_code(8'h80);
        send_code(8'h90);
        send_code(8'h39);            // space
        send_code(8'h37);            // '*' same in both tables
        send_code(CODE_ENTER);
        send_code(CODE_ENTER);       // enter on an empty line
        send_code(CODE_RSHIFT);      // right shift held across enter ...
        send_code(CODE_ENTER);
        send_code(8'h1E);            // ... and cleared by it: a
        send_code(8'h30);            // b
        send_code(8'h2E);            // c

        // Size dropped to 4 with three chars on the line: next append ends the line.
        set_line_size(9'd4);
        send_code(8'h20);            // d
        send_random(40, 6, 8, 1'b0);

        set_line_size(9'd0);         // clamps up to 2: every append ends a line
        send_random(30, 5, 8, 1'b0);
        set_line_size(9'd1);
        send_random(15, 5, 8, 1'b0);
        set_line_size(9'd3);
        send_random(40, 6, 8, 1'b0);

        // Clamped down to 256; long line to reach the last buffer slot.
        set_line_size(9'd511);
        send_random(290, 0, 0, 1'b1);

        set_line_size(9'd256);
        send_random(50, 6, 8, 1'b0);
        set_line_size(9'd300);
        send_random(40, 6, 8, 1'b0);
        repeat (2) begin
            set_line_size(9'($urandom_range(5, 40)));
            send_random(30, 6, 8, 1'b0);
        end

        s_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(negedge aclk);
            guard++;
        end while (writes_pending != 0 && guard < DRAIN_CAP);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && writes_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> scancode_line_editor.f
src/sle_pkg.sv
src/sle_in_stage.sv
src/sle_edit.sv
src/sle_out_queue.sv
src/scancode_line_editor.sv
test/line_edit_checker.sv
test/tb_scancode_line_editor.sv
